// ----- rtl/bce_pkg.sv -----
package bce_pkg;

    // limb-serial arithmetic: 18 limbs of 16 bits cover the scaled sum
    localparam int LIMB_W     = 16;
    localparam int LIMBS      = 18;
    localparam int ACC_W      = LIMBS * LIMB_W;
    localparam int LIMB_IDX_W = 5;
    localparam logic [LIMB_IDX_W-1:0] LAST_LIMB = LIMB_IDX_W'(LIMBS - 1);

    localparam int DEG_W   = 4;
    localparam int DEG_N   = 16;
    localparam int IDX_W   = 4;
    localparam int BINOM_W = 13;
    localparam int COORD_W = 32;
    localparam int COEF_W  = 45;
    localparam int T_W     = 17;
    localparam logic [T_W-1:0] ONE_Q16 = 17'h10000;

    // lane multiply-accumulate and its signed carry
    localparam int MAC_W    = 62;
    localparam int CARRY_W  = MAC_W - LIMB_W;
    // power register carry
    localparam int PMAC_W   = 34;
    localparam int PCARRY_W = PMAC_W - LIMB_W;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;

    // Pascal's triangle, row n and column k at entry n*16+k
    function automatic logic [DEG_N*DEG_N*BINOM_W-1:0] binom_table();
        logic [DEG_N*DEG_N*BINOM_W-1:0] tab;
        int r;
        int c;
        tab = '0;
        for (r = 0; r < DEG_N; r++)
        begin
            for (c = 0; c <= r; c++)
            begin
                if (c == 0 || c == r)
                begin
                    tab[(r * DEG_N + c) * BINOM_W +: BINOM_W] = BINOM_W'(1);
                end
                else
                begin
                    tab[(r * DEG_N + c) * BINOM_W +: BINOM_W] =
                        tab[((r - 1) * DEG_N + c - 1) * BINOM_W +: BINOM_W] +
                        tab[((r - 1) * DEG_N + c) * BINOM_W +: BINOM_W];
                end
            end
        end
        return tab;
    endfunction

    localparam logic [DEG_N*DEG_N*BINOM_W-1:0] BINOM_TAB = binom_table();

    function automatic logic [BINOM_W-1:0] binom(input logic [DEG_W-1:0] n,
                                                 input logic [DEG_W-1:0] k);
        return BINOM_TAB[int'({n, k}) * BINOM_W +: BINOM_W];
    endfunction

    // controller to datapath
    typedef struct packed {
        logic                  load;    // write one control point
        logic                  start;   // clear accumulators, latch t
        logic                  fetch;   // read point, look up binomial
        logic                  mult;    // form per-point coefficients
        logic                  pass;    // one limb of the MAC pass
        logic                  round;   // one limb of the rounding pass
        logic                  emit;    // load the output register
        logic                  first;   // first limb of a pass
        logic [LIMB_IDX_W-1:0] limb;
        logic [DEG_W-1:0]      step;
        logic [DEG_W-1:0]      degree;
    } bce_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } bce_status_t;

endpackage

// ----- rtl/bce_if.sv -----
// request channel into the block
interface bce_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 action;
    logic [bce_pkg::IDX_W-1:0]            point_index;
    logic signed [bce_pkg::COORD_W-1:0]   point_x;
    logic signed [bce_pkg::COORD_W-1:0]   point_y;
    logic [bce_pkg::T_W-1:0]              t_param;

    modport source (output valid, action, point_index, point_x, point_y, t_param,
                    input ready);
    modport sink   (input valid, action, point_index, point_x, point_y, t_param,
                    output ready);
endinterface

// result channel out of the block
interface bce_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bce_pkg::COORD_W-1:0]   curve_x;
    logic signed [bce_pkg::COORD_W-1:0]   curve_y;

    modport source (output valid, curve_x, curve_y, input ready);
    modport sink   (input valid, curve_x, curve_y, output ready);
endinterface

// ----- rtl/bezier_curve_evaluator.sv -----
// Channel    Dir  Handshake       Payload
// in_chan    in   valid/ready     action, point_index, point_x, point_y, t_param
// out_chan   out  valid/ready     curve_x, curve_y
// cfg        in   cfg_wr_en       cfg_wr_data (degree)
//
// A load request writes one control point and gives no result.
// An evaluate request occupies the block until its result is emitted; with n the clamped
// degree, each control point takes a fetch, a coefficient multiply and an
// 18-limb pass of the 16-bit serial multiply-accumulate, then an 18-limb rounding pass.
// Requests are taken while the sequencer is idle; a result waiting in the output
// register stalls only the end of the next evaluation.
// Reset clears the degree, the sequencer and the output valid; the point table is not cleared.
module bezier_curve_evaluator #(
    parameter int MAX_POINTS = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [bce_pkg::DEG_W-1:0]      cfg_wr_data,
    bce_in_if.sink                         in_chan,
    bce_out_if.source                      out_chan
);

    logic [bce_pkg::DEG_W-1:0]   degree_reg;
    logic [bce_pkg::DEG_W-1:0]   degree_eff;
    bce_pkg::bce_cmd_t           cmd;
    bce_pkg::bce_status_t        status;

    // degree register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            degree_reg <= cfg_wr_data;
        end
    end

    // degree limited by the table depth
    assign degree_eff = (32'(degree_reg) > MAX_POINTS - 1)
                      ? bce_pkg::DEG_W'(MAX_POINTS - 1) : degree_reg;

    bce_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_chan.valid),
        .in_action (in_chan.action),
        .in_ready  (in_chan.ready),
        .degree    (degree_eff),
        .status    (status),
        .cmd       (cmd)
    );

    bce_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .point_index (in_chan.point_index),
        .point_x     (in_chan.point_x),
        .point_y     (in_chan.point_y),
        .t_param     (in_chan.t_param),
        .out_valid   (out_chan.valid),
        .out_ready   (out_chan.ready),
        .curve_x     (out_chan.curve_x),
        .curve_y     (out_chan.curve_y)
    );

endmodule

// ----- rtl/bce_lane.sv -----
// One coordinate: limb-serial Horner MAC, then round and saturate.
module bce_lane
(
    input  logic                                 clk,
    input  bce_pkg::bce_cmd_t                    cmd,
    input  logic [bce_pkg::T_W-1:0]              s_val,
    input  logic [bce_pkg::LIMB_W-1:0]           pow_limb,
    input  logic [bce_pkg::BINOM_W-1:0]          binom_val,
    input  logic signed [bce_pkg::COORD_W-1:0]   coord,
    output logic signed [bce_pkg::COORD_W-1:0]   result
);

    localparam int LW = bce_pkg::LIMB_W;
    localparam int AW = bce_pkg::ACC_W;

    logic signed [bce_pkg::COEF_W-1:0]     coef_reg;
    logic signed [bce_pkg::COEF_W:0]       prod_c;
    logic [AW-1:0]                         acc_reg;
    logic [AW-1:0]                         acc_next;
    logic signed [bce_pkg::CARRY_W-1:0]    carry_reg;
    logic signed [bce_pkg::CARRY_W-1:0]    carry_in;
    logic signed [LW+bce_pkg::T_W+1:0]     prod_s;
    logic signed [bce_pkg::MAC_W-1:0]      prod_v;
    logic signed [bce_pkg::MAC_W-1:0]      mac;
    logic                                  rc_reg;
    logic                                  rc_in;
    logic                                  half_bit;
    logic [LW:0]                           rsum;
    logic [bce_pkg::LIMB_IDX_W-1:0]        deg_limb;
    logic                                  hit_lo;
    logic                                  hit_hi;
    logic                                  above;
    logic                                  ones_reg;
    logic                                  zeros_reg;
    logic                                  ones_in;
    logic                                  zeros_in;
    logic                                  sign_reg;
    logic [bce_pkg::COORD_W-1:0]           res_reg;

    // coefficient C(n,i) * P_i
    assign prod_c = $signed({1'b0, binom_val}) * coord;

    // A = A * s + t^i * coef, one limb per cycle
    assign carry_in = cmd.first ? '0 : carry_reg;
    assign prod_s   = $signed({1'b0, acc_reg[LW-1:0]}) * $signed({1'b0, s_val});
    assign prod_v   = $signed({1'b0, pow_limb}) * coef_reg;
    assign mac      = bce_pkg::MAC_W'(prod_s) + prod_v + bce_pkg::MAC_W'(carry_in);

    // rounding: add half at limb n-1, result sits in limbs n and n+1
    assign deg_limb = {1'b0, cmd.degree};
    assign half_bit = (cmd.degree != '0) &&
                      (cmd.limb == {1'b0, cmd.degree - bce_pkg::DEG_W'(1)});
    assign rc_in    = cmd.first ? 1'b0 : rc_reg;
    assign rsum     = {1'b0, acc_reg[LW-1:0]} + {1'b0, half_bit, 15'd0} + (LW + 1)'(rc_in);
    assign hit_lo   = (cmd.limb == deg_limb);
    assign hit_hi   = (cmd.limb == deg_limb + bce_pkg::LIMB_IDX_W'(1));
    assign above    = (cmd.limb > deg_limb + bce_pkg::LIMB_IDX_W'(1));
    assign ones_in  = cmd.first ? 1'b1 : ones_reg;
    assign zeros_in = cmd.first ? 1'b1 : zeros_reg;

    // accumulator rotates one limb per pass or rounding cycle
    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.start)
        begin
            acc_next = '0;
        end
        else if (cmd.pass)
        begin
            acc_next = {mac[LW-1:0], acc_reg[AW-1:LW]};
        end
        else if (cmd.round)
        begin
            acc_next = {rsum[LW-1:0], acc_reg[AW-1:LW]};
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (cmd.mult)
        begin
            coef_reg <= prod_c[bce_pkg::COEF_W-1:0];
        end
        if (cmd.pass)
        begin
            carry_reg <= mac[bce_pkg::MAC_W-1:LW];
        end
        if (cmd.round)
        begin
            rc_reg   <= rsum[LW];
            sign_reg <= rsum[LW-1];
            if (hit_lo)
            begin
                res_reg[LW-1:0] <= rsum[LW-1:0];
            end
            if (hit_hi)
            begin
                res_reg[2*LW-1:LW] <= rsum[LW-1:0];
                ones_reg  <= ones_in & rsum[LW-1];
                zeros_reg <= zeros_in & ~rsum[LW-1];
            end
            else if (above)
            begin
                ones_reg  <= ones_in & (&rsum[LW-1:0]);
                zeros_reg <= zeros_in & ~(|rsum[LW-1:0]);
            end
            else
            begin
                ones_reg  <= ones_in;
                zeros_reg <= zeros_in;
            end
        end
    end

    // saturate when bit 31 and the bits above it disagree
    assign result = (ones_reg || zeros_reg) ? $signed(res_reg)
                  : (sign_reg ? bce_pkg::SAT_MIN : bce_pkg::SAT_MAX);

endmodule

// ----- rtl/bce_datapath.sv -----
// Point table, power register, two coordinate lanes and output register.
module bce_datapath #(
    parameter int MAX_POINTS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bce_pkg::bce_cmd_t                    cmd,
    output bce_pkg::bce_status_t                 status,
    input  logic [bce_pkg::IDX_W-1:0]            point_index,
    input  logic signed [bce_pkg::COORD_W-1:0]   point_x,
    input  logic signed [bce_pkg::COORD_W-1:0]   point_y,
    input  logic [bce_pkg::T_W-1:0]              t_param,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [bce_pkg::COORD_W-1:0]   curve_x,
    output logic signed [bce_pkg::COORD_W-1:0]   curve_y
);

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int LW  = bce_pkg::LIMB_W;
    localparam int CW  = bce_pkg::COORD_W;
    localparam int ACW = bce_pkg::ACC_W;

    logic [2*CW-1:0]                   pt_mem [MAX_POINTS];
    logic [2*CW-1:0]                   pt_rd_reg;
    logic                              idx_ok;
    logic [bce_pkg::BINOM_W-1:0]       binom_reg;
    logic [bce_pkg::T_W-1:0]           t_sat;
    logic [bce_pkg::T_W-1:0]           t_reg;
    logic [bce_pkg::T_W-1:0]           s_reg;
    logic [ACW-1:0]                    pow_reg;
    logic [bce_pkg::PCARRY_W-1:0]      pcarry_reg;
    logic [bce_pkg::PCARRY_W-1:0]      pcarry_in;
    logic [LW+bce_pkg::T_W-1:0]        pow_prod;
    logic [bce_pkg::PMAC_W-1:0]        pmac;
    logic signed [CW-1:0]              lane_x;
    logic signed [CW-1:0]              lane_y;
    logic                              out_valid_reg;
    logic signed [CW-1:0]              curve_x_reg;
    logic signed [CW-1:0]              curve_y_reg;

    assign idx_ok = (32'(point_index) < 32'(MAX_POINTS));

    // control point table, x in the upper half
    always_ff @(posedge clk)
    begin
        if (cmd.load && idx_ok)
        begin
            pt_mem[AW'(point_index)] <= {point_x, point_y};
        end
        if (cmd.fetch)
        begin
            pt_rd_reg <= pt_mem[AW'(cmd.step)];
            binom_reg <= bce_pkg::binom(cmd.degree, cmd.step);
        end
    end

    // t clamped to one, s = 1 - t
    assign t_sat = (t_param > bce_pkg::ONE_Q16) ? bce_pkg::ONE_Q16 : t_param;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            t_reg <= t_sat;
            s_reg <= bce_pkg::ONE_Q16 - t_sat;
        end
    end

    // running power t^i, multiplied by t during each pass
    assign pcarry_in = cmd.first ? '0 : pcarry_reg;
    assign pow_prod  = pow_reg[LW-1:0] * t_reg;
    assign pmac      = bce_pkg::PMAC_W'(pow_prod) + bce_pkg::PMAC_W'(pcarry_in);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            pow_reg <= ACW'(1);
        end
        else if (cmd.pass)
        begin
            pow_reg    <= {pmac[LW-1:0], pow_reg[ACW-1:LW]};
            pcarry_reg <= pmac[bce_pkg::PMAC_W-1:LW];
        end
    end

    bce_lane u_lane_x
    (
        .clk       (clk),
        .cmd       (cmd),
        .s_val     (s_reg),
        .pow_limb  (pow_reg[LW-1:0]),
        .binom_val (binom_reg),
        .coord     ($signed(pt_rd_reg[2*CW-1:CW])),
        .result    (lane_x)
    );

    bce_lane u_lane_y
    (
        .clk       (clk),
        .cmd       (cmd),
        .s_val     (s_reg),
        .pow_limb  (pow_reg[LW-1:0]),
        .binom_val (binom_reg),
        .coord     ($signed(pt_rd_reg[CW-1:0])),
        .result    (lane_y)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            curve_x_reg <= lane_x;
            curve_y_reg <= lane_y;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign curve_x         = curve_x_reg;
    assign curve_y         = curve_y_reg;

    // a result is never dropped from the output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending one");

    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.emit))
        else $error("output valid without emit");

endmodule

// ----- rtl/bce_ctrl.sv -----
// Sequencer: per point fetch, coefficient, MAC pass; then rounding pass.
module bce_ctrl
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_action,
    output logic                           in_ready,
    input  logic [bce_pkg::DEG_W-1:0]      degree,
    input  bce_pkg::bce_status_t           status,
    output bce_pkg::bce_cmd_t              cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FETCH = 3'd1;
    localparam logic [2:0] ST_MULT  = 3'd2;
    localparam logic [2:0] ST_PASS  = 3'd3;
    localparam logic [2:0] ST_ROUND = 3'd4;
    localparam logic [2:0] ST_POST  = 3'd5;

    logic [2:0]                          state_reg;
    logic [2:0]                          state_next;
    logic [bce_pkg::DEG_W-1:0]           step_reg;
    logic [bce_pkg::DEG_W-1:0]           step_next;
    logic [bce_pkg::DEG_W-1:0]           n_reg;
    logic [bce_pkg::DEG_W-1:0]           n_next;
    logic [bce_pkg::LIMB_IDX_W-1:0]      limb_reg;
    logic [bce_pkg::LIMB_IDX_W-1:0]      limb_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        n_next     = n_reg;
        limb_next  = limb_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.limb   = limb_reg;
        cmd.step   = step_reg;
        cmd.degree = n_reg;
        cmd.first  = (limb_reg == '0);
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_action == bce_pkg::ACT_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        n_next     = degree;
                        step_next  = '0;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                limb_next  = '0;
                state_next = ST_PASS;
            end
            ST_PASS:
            begin
                cmd.pass = 1'b1;
                if (limb_reg == bce_pkg::LAST_LIMB)
                begin
                    limb_next = '0;
                    if (step_reg == n_reg)
                    begin
                        state_next = ST_ROUND;
                    end
                    else
                    begin
                        step_next  = step_reg + bce_pkg::DEG_W'(1);
                        state_next = ST_FETCH;
                    end
                end
                else
                begin
                    limb_next = limb_reg + bce_pkg::LIMB_IDX_W'(1);
                end
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (limb_reg == bce_pkg::LAST_LIMB)
                begin
                    limb_next  = '0;
                    state_next = ST_POST;
                end
                else
                begin
                    limb_next = limb_reg + bce_pkg::LIMB_IDX_W'(1);
                end
            end
            ST_POST:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            n_reg     <= '0;
            limb_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            n_reg     <= n_next;
            limb_reg  <= limb_next;
        end
    end

    // at most one datapath operation per cycle
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.start, cmd.fetch, cmd.mult, cmd.pass, cmd.round,
                  cmd.emit}))
        else $error("overlapping datapath commands");

    // point index never runs beyond the latched degree
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (step_reg <= n_reg))
        else $error("point index past degree");

    // a pass always starts at limb zero
    a_pass_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MULT) |=> (state_reg == ST_PASS && limb_reg == '0))
        else $error("pass did not start at limb zero");

    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (state_reg == ST_IDLE))
        else $error("sequencer busy after emit");

endmodule
